/* sv/srt_pkg.sv */
package srt_pkg;

  localparam int TABLE_ENTRIES  = 64;
  localparam int PROTOCOL_COUNT = 4;
  localparam int MAX_RESULTS    = 64;
  localparam int QUEUE_DEPTH    = 2;

  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int K_W     = $clog2(MAX_RESULTS + 1);
  localparam int QP_W    = $clog2(QUEUE_DEPTH);
  localparam int QC_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int OP_W    = 2;
  localparam int PROG_W  = 32;
  localparam int PROTO_W = 4;
  localparam int CORE_W  = 16;
  localparam int PORT_W  = 16;
  localparam int STAT_W  = 3;
  localparam int HIT_W   = 7;
  localparam int ENT_W   = PROG_W + PROTO_W + CORE_W + PORT_W;

  localparam logic [OP_W-1:0] OP_REG      = 2'd0;
  localparam logic [OP_W-1:0] OP_UNREG    = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOK_ONE = 2'd2;
  localparam logic [OP_W-1:0] OP_LOOK_ALL = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADPROTO = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic [PROG_W-1:0]         prog;
    logic [PROTO_W-1:0]        proto;
    logic signed [CORE_W-1:0]  core;
    logic [PORT_W-1:0]         port;
  } ent_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    ent_t            ent;
    logic            bad;
  } cmd_t;

endpackage

/* sv/srt_ram.sv */
module srt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/srt_front.sv */
module srt_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [srt_pkg::OP_W-1:0]       in_operation,
  input  logic [srt_pkg::PROG_W-1:0]     in_program_id,
  input  logic [srt_pkg::PROTO_W-1:0]    in_protocol,
  input  logic signed [srt_pkg::CORE_W-1:0] in_core_id,
  input  logic [srt_pkg::PORT_W-1:0]     in_port,
  output logic                           q_vld,
  output srt_pkg::cmd_t                  q_cmd,
  input  logic                           q_pop
);

  srt_pkg::cmd_t                 mem_r [srt_pkg::QUEUE_DEPTH];
  logic [srt_pkg::QP_W-1:0]      wp_r, rp_r;
  logic [srt_pkg::QC_W-1:0]      cnt_r;
  logic                          push, pop;
  srt_pkg::cmd_t                 cmd_in;

  assign busy  = (cnt_r == srt_pkg::QC_W'(srt_pkg::QUEUE_DEPTH));
  assign push  = start && !busy;
  assign q_vld = (cnt_r != '0);
  assign pop   = q_pop && q_vld;
  assign q_cmd = mem_r[rp_r];

  always_comb begin
    cmd_in.op        = in_operation;
    cmd_in.ent.prog  = in_program_id;
    cmd_in.ent.proto = in_protocol;
    cmd_in.ent.core  = in_core_id;
    cmd_in.ent.port  = in_port;
    cmd_in.bad       = (in_operation != srt_pkg::OP_LOOK_ALL) &&
                       ({1'b0, in_protocol} >=
                        (srt_pkg::PROTO_W + 1)'(srt_pkg::PROTOCOL_COUNT));
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cmd_in;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + srt_pkg::QC_W'(push) - srt_pkg::QC_W'(pop);
    end
  end

endmodule

/* sv/srt_back.sv */
module srt_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_vld,
  input  srt_pkg::cmd_t                     q_cmd,
  output logic                              q_pop,
  output logic                              out_strobe,
  output logic [srt_pkg::STAT_W-1:0]        out_status,
  output logic                              out_has_entry,
  output logic [srt_pkg::PROG_W-1:0]        out_entry_program,
  output logic [srt_pkg::PROTO_W-1:0]       out_entry_protocol,
  output logic signed [srt_pkg::CORE_W-1:0] out_entry_core,
  output logic [srt_pkg::PORT_W-1:0]        out_entry_port,
  output logic [srt_pkg::HIT_W-1:0]         out_hit_count,
  output logic                              out_last
);

  localparam int TE = srt_pkg::TABLE_ENTRIES;
  localparam int IW = srt_pkg::IDX_W;
  localparam int CW = srt_pkg::CNT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]    st_r, st_nxt;
  srt_pkg::cmd_t cmd_r, cmd_nxt;
  logic [TE-1:0] valid_r, valid_nxt;
  logic [IW-1:0] ord_r [TE];
  logic [IW-1:0] ord_nxt [TE];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;
  logic          found_r, found_nxt;
  logic [IW-1:0] fidx_r, fidx_nxt;
  logic          pres_r, pres_nxt;
  logic [CW-1:0] hits_r, hits_nxt;
  logic [srt_pkg::PROTO_W-1:0] p_r, p_nxt;
  logic [srt_pkg::K_W-1:0]     k_r, k_nxt;
  logic          done_r, done_nxt;

  logic                              o_stb_r, o_stb_nxt;
  logic [srt_pkg::STAT_W-1:0]        o_stat_r, o_stat_nxt;
  logic                              o_has_r, o_has_nxt;
  srt_pkg::ent_t                     o_ent_r, o_ent_nxt;
  logic [srt_pkg::HIT_W-1:0]         o_hit_r, o_hit_nxt;
  logic                              o_last_r, o_last_nxt;

  logic                         ram_we;
  logic [IW-1:0]                ram_raddr;
  logic [srt_pkg::ENT_W-1:0]    ram_rdata;
  srt_pkg::ent_t                e;
  logic [IW-1:0]                free_idx;
  logic                         full;
  logic [srt_pkg::PROTO_W-1:0]  plo, plast;
  logic [TE-1:0]                eqv, ge;
  logic                         pm, em, emit_last;

  srt_ram #(.WIDTH(srt_pkg::ENT_W), .DEPTH(TE)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata (cmd_r.ent),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign e = srt_pkg::ent_t'(ram_rdata);

  always_comb begin
    free_idx = '0;
    for (int i = TE - 1; i >= 0; i--) begin
      if (!valid_r[i]) free_idx = IW'(i);
    end
    full = &valid_r;
    plo   = (cmd_r.op == srt_pkg::OP_LOOK_ALL) ? '0 : cmd_r.ent.proto;
    plast = (cmd_r.op == srt_pkg::OP_LOOK_ALL) ?
            srt_pkg::PROTO_W'(srt_pkg::PROTOCOL_COUNT - 1) : cmd_r.ent.proto;
    for (int i = 0; i < TE; i++) begin
      eqv[i] = (ord_r[i] == fidx_r) && (CW'(i) < cnt_r);
    end
    for (int i = 0; i < TE; i++) begin
      ge[i] = 1'b0;
      for (int j = 0; j < TE; j++) begin
        if (j <= i) ge[i] = ge[i] | eqv[j];
      end
    end
    pm = valid_r[rd_idx_r] && (e.prog == cmd_r.ent.prog);
    em = pm && (e.proto == cmd_r.ent.proto) && (e.core == cmd_r.ent.core) &&
         (e.port == cmd_r.ent.port);
    emit_last = (int'(k_r) + 1 == int'(hits_r)) ||
                (int'(k_r) + 1 == srt_pkg::MAX_RESULTS);
  end

  assign ram_we    = (st_r == S_FIN) && (cmd_r.op == srt_pkg::OP_REG) &&
                     !found_r && !full;
  assign ram_raddr = (st_r == S_EMIT) ? ord_r[0] : pos_r[IW-1:0];
  assign q_pop     = (st_r == S_IDLE) && q_vld;

  always_comb begin
    st_nxt     = st_r;
    cmd_nxt    = cmd_r;
    valid_nxt  = valid_r;
    ord_nxt    = ord_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    rd_vld_nxt = 1'b0;
    rd_idx_nxt = pos_r[IW-1:0];
    found_nxt  = found_r;
    fidx_nxt   = fidx_r;
    pres_nxt   = pres_r;
    hits_nxt   = hits_r;
    p_nxt      = p_r;
    k_nxt      = k_r;
    done_nxt   = done_r;
    o_stb_nxt  = 1'b0;
    o_stat_nxt = srt_pkg::ST_OK;
    o_has_nxt  = 1'b0;
    o_ent_nxt  = '0;
    o_hit_nxt  = '0;
    o_last_nxt = 1'b1;
    case (st_r)
      S_IDLE: begin
        if (q_vld) begin
          cmd_nxt = q_cmd;
          if (q_cmd.bad) begin
            o_stb_nxt  = 1'b1;
            o_stat_nxt = srt_pkg::ST_BADPROTO;
          end else begin
            st_nxt    = S_SCAN;
            pos_nxt   = '0;
            found_nxt = 1'b0;
            pres_nxt  = 1'b0;
            hits_nxt  = '0;
          end
        end
      end
      S_SCAN: begin
        if (pos_r < CW'(TE)) begin
          rd_vld_nxt = 1'b1;
          pos_nxt    = pos_r + 1'b1;
        end
        if (rd_vld_r) begin
          if (em && !found_r) begin
            found_nxt = 1'b1;
            fidx_nxt  = rd_idx_r;
          end
          if (pm) pres_nxt = 1'b1;
          if (pm && (e.proto >= plo) && (e.proto <= plast)) hits_nxt = hits_r + 1'b1;
          if (rd_idx_r == IW'(TE - 1)) st_nxt = S_FIN;
        end
      end
      S_FIN: begin
        st_nxt    = S_IDLE;
        o_stb_nxt = 1'b1;
        case (cmd_r.op)
          srt_pkg::OP_REG: begin
            if (found_r) begin
              o_stat_nxt = srt_pkg::ST_DUP;
            end else if (full) begin
              o_stat_nxt = srt_pkg::ST_FULL;
            end else begin
              valid_nxt[free_idx] = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
              ord_nxt[0] = free_idx;
              for (int i = 1; i < TE; i++) ord_nxt[i] = ord_r[i-1];
            end
          end
          srt_pkg::OP_UNREG: begin
            if (!found_r) begin
              o_stat_nxt = srt_pkg::ST_NOTFOUND;
            end else begin
              valid_nxt[fidx_r] = 1'b0;
              cnt_nxt = cnt_r - 1'b1;
              for (int i = 0; i < TE - 1; i++) begin
                if (ge[i]) ord_nxt[i] = ord_r[i+1];
              end
            end
          end
          default: begin
            if (!pres_r) begin
              o_stat_nxt = srt_pkg::ST_NOTFOUND;
            end else if (hits_r != '0) begin
              o_stb_nxt = 1'b0;
              st_nxt    = S_EMIT;
              p_nxt     = plo;
              pos_nxt   = '0;
              k_nxt     = '0;
              done_nxt  = 1'b0;
            end
          end
        endcase
      end
      S_EMIT: begin
        if (pos_r < CW'(TE)) begin
          rd_vld_nxt = (pos_r < cnt_r);
          pos_nxt    = pos_r + 1'b1;
          for (int i = 0; i < TE - 1; i++) ord_nxt[i] = ord_r[i+1];
          ord_nxt[TE-1] = ord_r[0];
        end else if (p_r == plast) begin
          st_nxt = S_IDLE;
        end else begin
          p_nxt   = p_r + 1'b1;
          pos_nxt = '0;
        end
        if (rd_vld_r && !done_r && (e.prog == cmd_r.ent.prog) && (e.proto == p_r)) begin
          o_stb_nxt  = 1'b1;
          o_has_nxt  = 1'b1;
          o_ent_nxt  = e;
          o_hit_nxt  = srt_pkg::HIT_W'(hits_r);
          o_last_nxt = emit_last;
          k_nxt      = k_r + 1'b1;
          if (emit_last) done_nxt = 1'b1;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    ord_r    <= ord_nxt;
    rd_idx_r <= rd_idx_nxt;
    fidx_r   <= fidx_nxt;
    p_r      <= p_nxt;
    o_stat_r <= o_stat_nxt;
    o_has_r  <= o_has_nxt;
    o_ent_r  <= o_ent_nxt;
    o_hit_r  <= o_hit_nxt;
    o_last_r <= o_last_nxt;
    if (!rst_n) begin
      st_r     <= S_IDLE;
      valid_r  <= '0;
      cnt_r    <= '0;
      pos_r    <= '0;
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
      pres_r   <= 1'b0;
      hits_r   <= '0;
      k_r      <= '0;
      done_r   <= 1'b0;
      o_stb_r  <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      valid_r  <= valid_nxt;
      cnt_r    <= cnt_nxt;
      pos_r    <= pos_nxt;
      rd_vld_r <= rd_vld_nxt;
      found_r  <= found_nxt;
      pres_r   <= pres_nxt;
      hits_r   <= hits_nxt;
      k_r      <= k_nxt;
      done_r   <= done_nxt;
      o_stb_r  <= o_stb_nxt;
    end
  end

  assign out_strobe         = o_stb_r;
  assign out_status         = o_stat_r;
  assign out_has_entry      = o_has_r;
  assign out_entry_program  = o_ent_r.prog;
  assign out_entry_protocol = o_ent_r.proto;
  assign out_entry_core     = o_ent_r.core;
  assign out_entry_port     = o_ent_r.port;
  assign out_hit_count      = o_hit_r;
  assign out_last           = o_last_r;

`ifndef SYNTHESIS
  a_cnt_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(cnt_r))
    else $error("valid count mismatch");
  a_emit_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_EMIT) |=> $stable(valid_r))
    else $error("table changed during lookup");
  a_write_fin: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (cmd_r.op == srt_pkg::OP_REG) && !valid_r[free_idx])
    else $error("write to occupied slot");
  a_emit_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (o_stb_r && o_has_r) |-> (o_hit_r != '0))
    else $error("entry word without hits");
`endif

endmodule

/* sv/service_port_registry_table.sv */
// channel | ports                                   | handshake
// in      | in_operation .. in_port                 | start & !busy
// out     | out_status .. out_last                  | out_strobe, one cycle, no stall
// Register/unregister: a scan of every slot over the RAM read port, then a finish step that updates the table.
// Lookup with hits adds one rotation of the age order per protocol.
// A two-word queue takes commands while the executor works; busy rises when it is full.
// Reset is synchronous, rst_n low; the slot table is empty after it.
module service_port_registry_table (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [srt_pkg::OP_W-1:0]          in_operation,
  input  logic [srt_pkg::PROG_W-1:0]        in_program_id,
  input  logic [srt_pkg::PROTO_W-1:0]       in_protocol,
  input  logic signed [srt_pkg::CORE_W-1:0] in_core_id,
  input  logic [srt_pkg::PORT_W-1:0]        in_port,
  output logic                              out_strobe,
  output logic [srt_pkg::STAT_W-1:0]        out_status,
  output logic                              out_has_entry,
  output logic [srt_pkg::PROG_W-1:0]        out_entry_program,
  output logic [srt_pkg::PROTO_W-1:0]       out_entry_protocol,
  output logic signed [srt_pkg::CORE_W-1:0] out_entry_core,
  output logic [srt_pkg::PORT_W-1:0]        out_entry_port,
  output logic [srt_pkg::HIT_W-1:0]         out_hit_count,
  output logic                              out_last
);

  logic          q_vld, q_pop;
  srt_pkg::cmd_t q_cmd;

  srt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_program_id (in_program_id),
    .in_protocol   (in_protocol),
    .in_core_id    (in_core_id),
    .in_port       (in_port),
    .q_vld         (q_vld),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop)
  );

  srt_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_vld              (q_vld),
    .q_cmd              (q_cmd),
    .q_pop              (q_pop),
    .out_strobe         (out_strobe),
    .out_status         (out_status),
    .out_has_entry      (out_has_entry),
    .out_entry_program  (out_entry_program),
    .out_entry_protocol (out_entry_protocol),
    .out_entry_core     (out_entry_core),
    .out_entry_port     (out_entry_port),
    .out_hit_count      (out_hit_count),
    .out_last           (out_last)
  );

endmodule
